>>> rtl/mbbc_pkg.sv
`default_nettype none
package mbbc_pkg;
  localparam int SLOTS   = 32;
  localparam int DEVICES = 16;
  localparam int SW      = $clog2(SLOTS);
  localparam int DW      = 4;
  localparam int CNT_MAX = 255;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_PIN     = 3'd3,
    OP_UNPIN   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DEV  = 2'd1,
    ST_FULL = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DOP_NONE  = 2'd0,
    DOP_READ  = 2'd1,
    DOP_WRITE = 2'd2
  } dop_t;

  typedef enum logic [1:0] {
    REG_FAILED = 2'd0,
    REG_BAD    = 2'd1,
    REG_MIRROR = 2'd2
  } reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RD, S_SCAN_HIT, S_SCAN_FREE, S_CNT_RD, S_APPLY,
    S_SHIFT, S_OUT1, S_OUT2
  } state_t;

  typedef struct packed {
    logic [SW-1:0] slot_out;
    logic          hit;
    logic          data_valid;
    logic [1:0]    disk_op;
    logic          disk_id;
    logic [16:0]   phys_block;
    logic [1:0]    status;
    logic          last;
  } res_t;
endpackage
`default_nettype wire

>>> rtl/mirrored_block_buffer_cache_core.sv
`default_nettype none
// Channel | Direction | Payload
// in_     | slave     | tdata: operation[2:0] device[6:3] block[22:7] slot[27:23]
// out_    | master    | tdata: slot_out[4:0] hit[5] data_valid[6] disk_op[8:7]
//         |           |        disk_id[9] phys_block[26:10] status[28:27]; tlast
// cfg_    | APB       | 0 failed_disk, 4 bad_block, 8 mirror_base
// A read scans the slot memories one entry a cycle: a hit scan over recency, and on a
// miss another free scan. A release that frees its slot runs a rank shift pass, and a
// write to both disks gives a second result. After reset a clearing pass loads the
// memories; no item is taken during it.
// A stalled output holds its item; the next input waits.
module mirrored_block_buffer_cache_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // operation, device, block, slot from bit 0
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // slot_out,hit,data_valid,disk_op,disk_id,phys_block,status
  output logic        out_tlast,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mbbc_pkg::*;

  // Slot memories: one entry per slot, registered reads.
  logic [DW-1:0]  tdev_m [SLOTS];
  logic [15:0]    tblk_m [SLOTS];
  logic           val_m  [SLOTS];
  logic [7:0]     cnt_m  [SLOTS];
  logic [SW-1:0]  rank_m [SLOTS];

  logic [1:0]  failed_r;
  logic [16:0] bad_r;
  logic [15:0] mirror_r;

  state_t state_r, state_nxt;
  logic [2:0]    op_r;
  logic [DW-1:0] dev_r;
  logic [15:0]   blk_r;
  logic [SW:0]   idx_r, idx_nxt;    // scan index
  logic [SW-1:0] tgt_r, tgt_nxt;    // chosen slot
  logic [SW-1:0] best_r, best_nxt;  // best rank so far
  logic          found_r, found_nxt;
  logic          hit_r, hit_nxt;
  res_t          r1_r, r1_nxt, r2_r, r2_nxt;
  logic          two_r, two_nxt;
  logic [SW-1:0] trank_r, trank_nxt;

  // memory ports
  logic [SW-1:0] ra;
  logic          we;
  logic [SW-1:0] wa;
  logic [DW-1:0] w_dev; logic [15:0] w_blk; logic w_val; logic [7:0] w_cnt;
  logic [SW-1:0] w_rank;
  logic          we_tag, we_val, we_cnt, we_rank;
  logic [DW-1:0] q_dev; logic [15:0] q_blk; logic q_val; logic [7:0] q_cnt;
  logic [SW-1:0] q_rank;

  always_ff @(posedge clk) begin
    if (we && we_tag) begin tdev_m[wa] <= w_dev; tblk_m[wa] <= w_blk; end
    if (we && we_val) val_m[wa] <= w_val;
    if (we && we_cnt) cnt_m[wa] <= w_cnt;
    if (we && we_rank) rank_m[wa] <= w_rank;
    q_dev <= tdev_m[ra]; q_blk <= tblk_m[ra]; q_val <= val_m[ra];
    q_cnt <= cnt_m[ra];  q_rank <= rank_m[ra];
  end

  // config
  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r <= 2'b11; bad_r <= 17'h1FFFF; mirror_r <= 16'd1000;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FAILED: failed_r <= cfg_pwdata[1:0];
        REG_BAD:    bad_r    <= cfg_pwdata[16:0];
        REG_MIRROR: mirror_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      REG_FAILED: cfg_prdata = {{30{failed_r[1]}}, failed_r};
      REG_BAD:    cfg_prdata = {{15{bad_r[16]}}, bad_r};
      REG_MIRROR: cfg_prdata = {16'd0, mirror_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  wire fd0 = (failed_r == 2'b00);
  wire fd1 = (failed_r == 2'b01);
  function automatic logic bb(input logic [15:0] b, input logic [16:0] badv);
    return (badv != 17'h1FFFF) && (badv == {1'b0, b});
  endfunction

  assign in_tready = (state_r == S_IDLE);
  wire in_acc = in_tvalid && in_tready;

  wire [SW-1:0] idx = idx_r[SW-1:0];
  wire [SW-1:0] last_idx = SW'(SLOTS - 1);
  wire [SW:0]   scan_end = (SW+1)'(SLOTS);

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; tgt_nxt = tgt_r; best_nxt = best_r;
    found_nxt = found_r; hit_nxt = hit_r; r1_nxt = r1_r; r2_nxt = r2_r;
    two_nxt = two_r; trank_nxt = trank_r;
    ra = idx; we = 1'b0; wa = idx; w_dev = dev_r; w_blk = blk_r; w_val = 1'b0;
    w_cnt = 8'd0; w_rank = idx; we_tag = 1'b0; we_val = 1'b0; we_cnt = 1'b0;
    we_rank = 1'b0;
    case (state_r)
      S_CLR: begin
        // load reset contents one entry a cycle
        we = 1'b1; we_tag = 1'b1; we_val = 1'b1; we_cnt = 1'b1; we_rank = 1'b1;
        w_dev = '0; w_blk = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx == last_idx) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        idx_nxt = '0; found_nxt = 1'b0; best_nxt = '0; hit_nxt = 1'b0;
        ra = '0;
        if (in_acc) begin
          if (in_tdata[2:0] == OP_READ) begin
            if (int'(in_tdata[6:3]) >= DEVICES) begin
              r1_nxt = '0; r1_nxt.status = ST_DEV; r1_nxt.last = 1'b1;
              two_nxt = 1'b0; state_nxt = S_OUT1;
            end else state_nxt = S_SCAN_HIT;
          end else if (in_tdata[2:0] > OP_UNPIN) begin
            r1_nxt = '0; r1_nxt.slot_out = in_tdata[27:23]; r1_nxt.last = 1'b1;
            two_nxt = 1'b0; state_nxt = S_OUT1;
          end else begin
            ra = in_tdata[23 +: SW]; tgt_nxt = in_tdata[23 +: SW];
            state_nxt = S_APPLY;
          end
        end
      end
      S_SCAN_HIT: begin
        // data for idx-1 is on q; track the highest-rank tag match
        if (idx_r != '0) begin
          if (q_dev == dev_r && q_blk == blk_r && (!found_r || q_rank > best_r)) begin
            found_nxt = 1'b1; best_nxt = q_rank; tgt_nxt = idx - 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
        ra = idx;
        if (idx_r == scan_end) begin
          idx_nxt = '0; ra = '0;
          if (found_nxt) begin hit_nxt = 1'b1; ra = tgt_nxt; state_nxt = S_APPLY; end
          else begin best_nxt = '1; state_nxt = S_SCAN_FREE; end
        end
      end
      S_SCAN_FREE: begin
        // lowest-rank slot with zero count
        if (idx_r != '0) begin
          if (q_cnt == 8'd0 && (!found_r || q_rank < best_r)) begin
            found_nxt = 1'b1; best_nxt = q_rank; tgt_nxt = idx - 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
        ra = idx;
        if (idx_r == scan_end) begin
          ra = tgt_nxt;
          if (found_nxt) state_nxt = S_APPLY;
          else begin
            r1_nxt = '0; r1_nxt.status = ST_FULL; r1_nxt.last = 1'b1;
            two_nxt = 1'b0; state_nxt = S_OUT1;
          end
        end
      end
      S_APPLY: begin
        // q holds entry tgt_r
        ra = tgt_r;
        r1_nxt = '0; r2_nxt = '0; two_nxt = 1'b0;
        r1_nxt.slot_out = tgt_r; r1_nxt.last = 1'b1;
        state_nxt = S_OUT1;
        wa = tgt_r;
        case (op_r)
          OP_READ: begin
            logic v;
            logic [15:0] b;
            v = hit_r ? q_val : 1'b0;
            b = blk_r;
            r1_nxt.hit = hit_r;
            we = 1'b1; we_cnt = 1'b1;
            if (hit_r) begin
              if (q_cnt == 8'(CNT_MAX)) begin r1_nxt.status = ST_SAT; w_cnt = q_cnt; end
              else w_cnt = q_cnt + 8'd1;
            end else begin
              we_tag = 1'b1; w_cnt = 8'd1;
            end
            if (!v) begin
              if (!fd0 && !bb(b, bad_r)) begin
                r1_nxt.disk_op = DOP_READ; r1_nxt.phys_block = {1'b0, b}; v = 1'b1;
              end else if (!fd1) begin
                r1_nxt.disk_op = DOP_READ; r1_nxt.disk_id = 1'b1;
                r1_nxt.phys_block = {1'b0, b} + {1'b0, mirror_r}; v = 1'b1;
              end
            end
            we_val = 1'b1; w_val = v;
            r1_nxt.data_valid = v;
          end
          OP_WRITE: begin
            logic w0, w1;
            w0 = !fd0 && !bb(q_blk, bad_r);
            w1 = !fd1;
            r1_nxt.data_valid = q_val;
            r2_nxt = r1_nxt;
            r2_nxt.disk_op = DOP_WRITE; r2_nxt.disk_id = 1'b1;
            r2_nxt.phys_block = {1'b0, q_blk} + {1'b0, mirror_r};
            if (w0) begin
              r1_nxt.disk_op = DOP_WRITE; r1_nxt.phys_block = {1'b0, q_blk};
              r1_nxt.last = !w1; two_nxt = w1;
            end else if (w1) r1_nxt = r2_nxt;
          end
          default: begin
            r1_nxt.data_valid = q_val;
            we = 1'b1; we_cnt = 1'b1; w_cnt = q_cnt;
            if (op_r == OP_PIN) begin
              if (q_cnt == 8'(CNT_MAX)) r1_nxt.status = ST_SAT;
              else w_cnt = q_cnt + 8'd1;
            end else if (q_cnt == 8'd0) r1_nxt.status = ST_SAT;
            else begin
              w_cnt = q_cnt - 8'd1;
              if (op_r == OP_RELEASE && q_cnt == 8'd1) begin
                trank_nxt = q_rank; idx_nxt = '0; ra = '0; state_nxt = S_SHIFT;
              end
            end
          end
        endcase
      end
      S_SHIFT: begin
        // move slot to most recent: ranks above it drop by one
        if (idx_r != '0) begin
          wa = idx - 1'b1; we = 1'b1; we_rank = 1'b1;
          if (wa == tgt_r) w_rank = last_idx;
          else if (q_rank > trank_r) w_rank = q_rank - 1'b1;
          else w_rank = q_rank;
        end
        idx_nxt = idx_r + 1'b1;
        ra = idx;
        if (idx_r == scan_end) state_nxt = S_OUT1;
      end
      S_OUT1: if (out_tready) state_nxt = two_r ? S_OUT2 : S_IDLE;
      S_OUT2: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; idx_r <= '0; found_r <= 1'b0; hit_r <= 1'b0; two_r <= 1'b0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; found_r <= found_nxt;
      hit_r <= hit_nxt; two_r <= two_nxt;
    end
  end
  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt; best_r <= best_nxt; r1_r <= r1_nxt; r2_r <= r2_nxt;
    trank_r <= trank_nxt;
    if (in_acc) begin
      op_r <= in_tdata[2:0]; dev_r <= in_tdata[6:3]; blk_r <= in_tdata[22:7];
    end
  end

  res_t cur;
  assign cur = (state_r == S_OUT2) ? r2_r : r1_r;
  assign out_tvalid = (state_r == S_OUT1) || (state_r == S_OUT2);
  assign out_tdata = {3'd0, cur.status, cur.phys_block, cur.disk_id, cur.disk_op,
                      cur.data_valid, cur.hit, cur.slot_out};
  assign out_tlast = cur.last;

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == S_OUT1 || state_r == S_OUT2)) else $error("stray out");
  a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT2) |-> out_tlast) else $error("second result not last");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("dropped output");
endmodule
`default_nettype wire

>>> bench/mirrored_block_buffer_cache_checker.sv
`default_nettype none
module mirrored_block_buffer_cache_checker
  import mbbc_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [31:0] in_tdata,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [31:0] out_tdata,
  input  wire        out_tlast,
  input  wire        cfg_psel,
  input  wire        cfg_penable,
  input  wire        cfg_pwrite,
  input  wire        cfg_pready,
  input  wire [3:0]  cfg_paddr,
  input  wire [31:0] cfg_pwdata,
  output int         mismatches,
  output int         pending,
  output int         results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the cache tags, counts and recency order
  logic [3:0]    tag_dev  [SLOTS];
  logic [15:0]   tag_blk  [SLOTS];
  logic          valid    [SLOTS];
  logic [7:0]    refs     [SLOTS];
  logic [SW-1:0] rank     [SLOTS];
  logic [1:0]    failed_disk;
  logic [16:0]   bad_block;
  logic [15:0]   mirror_base;
  res_t          expected_q[$];

  function automatic bit disk0_bad(input logic [15:0] blk);
    return bad_block != 17'h1FFFF && bad_block == {1'b0, blk};
  endfunction

  task automatic queue_result(input logic [SW-1:0] sl, input logic hit, input logic dv,
                              input dop_t dop, input logic disk, input logic [16:0] pb,
                              input status_t st, input logic last);
    res_t r;
    r.slot_out = sl; r.hit = hit; r.data_valid = dv; r.disk_op = dop;
    r.disk_id = disk; r.phys_block = pb; r.status = st; r.last = last;
    expected_q.push_back(r);
  endtask

  task automatic predict_cache_op(input logic [31:0] d);
    logic [2:0]    op;
    logic [3:0]    dev;
    logic [15:0]   blk;
    logic [SW-1:0] sl;
    logic [15:0]   b0;
    int            s;
    bit            hit, w0, w1;
    status_t       st;
    dop_t          dop;
    logic          disk;
    logic [16:0]   pb;
    op = d[2:0]; dev = d[6:3]; blk = d[22:7]; sl = d[27:23];
    st = ST_OK; dop = DOP_NONE; disk = 1'b0; pb = '0; hit = 1'b0;
    if (op == OP_READ) begin
      if (int'(dev) >= DEVICES) begin
        queue_result('0, 0, 0, DOP_NONE, 0, '0, ST_DEV, 1);
        return;
      end
      // stale tags match too: valid bit is not consulted
      s = -1;
      for (int i = 0; i < SLOTS; i++)
        if (tag_dev[i] == dev && tag_blk[i] == blk && (s < 0 || rank[i] > rank[s])) s = i;
      if (s >= 0) begin
        hit = 1'b1;
        if (refs[s] == 8'(CNT_MAX)) st = ST_SAT;
        else refs[s]++;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (refs[i] == 0 && (s < 0 || rank[i] < rank[s])) s = i;
        if (s < 0) begin
          queue_result('0, 0, 0, DOP_NONE, 0, '0, ST_FULL, 1);
          return;
        end
        tag_dev[s] = dev; tag_blk[s] = blk; valid[s] = 1'b0; refs[s] = 8'd1;
      end
      if (!valid[s]) begin
        if (failed_disk != 2'b00 && !disk0_bad(blk)) begin
          dop = DOP_READ; disk = 1'b0; pb = {1'b0, blk}; valid[s] = 1'b1;
        end else if (failed_disk != 2'b01) begin
          dop = DOP_READ; disk = 1'b1; pb = {1'b0, blk} + {1'b0, mirror_base};
          valid[s] = 1'b1;
        end
      end
      queue_result(SW'(s), hit, valid[s], dop, disk, pb, st, 1);
      return;
    end
    if (op > OP_UNPIN) begin
      queue_result(sl, 0, 0, DOP_NONE, 0, '0, ST_OK, 1);
      return;
    end
    if (op == OP_WRITE) begin
      b0 = tag_blk[sl];
      w0 = failed_disk != 2'b00 && !disk0_bad(b0);
      w1 = failed_disk != 2'b01;
      if (w0) queue_result(sl, 0, valid[sl], DOP_WRITE, 0, {1'b0, b0}, ST_OK, !w1);
      if (w1) queue_result(sl, 0, valid[sl], DOP_WRITE, 1,
                           {1'b0, b0} + {1'b0, mirror_base}, ST_OK, 1);
      if (!w0 && !w1) queue_result(sl, 0, valid[sl], DOP_NONE, 0, '0, ST_OK, 1);
      return;
    end
    if (op == OP_PIN) begin
      if (refs[sl] == 8'(CNT_MAX)) st = ST_SAT;
      else refs[sl]++;
    end else if (refs[sl] == 0) begin
      st = ST_SAT;
    end else begin
      refs[sl]--;
      // a freed slot becomes most recent
      if (op == OP_RELEASE && refs[sl] == 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (rank[i] > rank[sl]) rank[i]--;
        rank[sl] = SW'(SLOTS - 1);
      end
    end
    queue_result(sl, 0, valid[sl], DOP_NONE, 0, '0, st, 1);
  endtask

  always @(posedge clk) begin
    res_t got, exp;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_dev[i] = '0; tag_blk[i] = '0; valid[i] = 1'b0; refs[i] = '0;
        rank[i] = SW'(i);
      end
      failed_disk = 2'b11; bad_block = 17'h1FFFF; mirror_base = 16'd1000;
      expected_q.delete();
      mismatches = 0; results_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_t'(cfg_paddr[3:2]))
          REG_FAILED: failed_disk = cfg_pwdata[1:0];
          REG_BAD:    bad_block   = cfg_pwdata[16:0];
          REG_MIRROR: mirror_base = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.slot_out = out_tdata[4:0];    got.hit = out_tdata[5];
        got.data_valid = out_tdata[6];    got.disk_op = out_tdata[8:7];
        got.disk_id = out_tdata[9];       got.phys_block = out_tdata[26:10];
        got.status = out_tdata[28:27];    got.last = out_tlast;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: slot=%0d op=%0d st=%0d",
                   $time, got.slot_out, got.disk_op, got.status);
        end else begin
          exp = expected_q.pop_front();
          if (got.slot_out !== exp.slot_out || got.hit !== exp.hit ||
              got.data_valid !== exp.data_valid || got.disk_op !== exp.disk_op ||
              got.disk_id !== exp.disk_id || got.phys_block !== exp.phys_block ||
              got.status !== exp.status || got.last !== exp.last) begin
            mismatches++;
            $display("%0t: expected slot=%0d hit=%0d dv=%0d dop=%0d disk=%0d pb=%0d st=%0d last=%0d",
                     $time, exp.slot_out, exp.hit, exp.data_valid, exp.disk_op,
                     exp.disk_id, exp.phys_block, exp.status, exp.last);
            $display("%0t: actual   slot=%0d hit=%0d dv=%0d dop=%0d disk=%0d pb=%0d st=%0d last=%0d",
                     $time, got.slot_out, got.hit, got.data_valid, got.disk_op,
                     got.disk_id, got.phys_block, got.status, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) predict_cache_op(in_tdata);
    end
    pending = expected_q.size();
  end
endmodule
`default_nettype wire

>>> bench/mirrored_block_buffer_cache_core_tb.sv
`default_nettype none
module mirrored_block_buffer_cache_core_tb;
  import mbbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // operation, device, block, slot from bit 0
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // slot_out, hit, data_valid, disk_op, disk_id, phys_block, status
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches, pending, results_seen;
  int items_sent = 0;
  int gap_pct = 0;     // chance in a hundred that the sender idles a cycle
  int stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle

  always #10 clk = ~clk;

  mirrored_block_buffer_cache_core i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  mirrored_block_buffer_cache_checker i_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .mismatches, .pending, .results_seen
  );

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Hold one item on the input until it is taken; idle at random first.
  task automatic send_item(input logic [2:0] op, input logic [3:0] dev,
                           input logic [15:0] blk, input logic [4:0] sl);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, sl, blk, dev, op};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic reg_write(input reg_t idx, input logic [31:0] value);
    @(negedge clk);
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drain all results, then allow for a read still scanning both passes.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * SLOTS + 20) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] fd, input logic [31:0] bad,
                          input logic [31:0] mirror);
    wait_idle();
    reg_write(REG_FAILED, fd);
    reg_write(REG_BAD, bad);
    reg_write(REG_MIRROR, mirror);
  endtask

  // Mostly a small tag space so reads hit and counts move up and down.
  task automatic random_item();
    int          pick;
    logic [2:0]  op;
    logic [3:0]  dev;
    logic [15:0] blk;
    pick = $urandom_range(99);
    if (pick < 40)      op = OP_READ;
    else if (pick < 55) op = OP_WRITE;
    else if (pick < 75) op = OP_RELEASE;
    else if (pick < 85) op = OP_PIN;
    else if (pick < 95) op = OP_UNPIN;
    else                op = 3'($urandom_range(7, 5));
    dev = ($urandom_range(9) < 7) ? 4'($urandom_range(3)) : 4'($urandom);
    blk = ($urandom_range(9) < 7) ? 16'($urandom_range(15)) : 16'($urandom);
    send_item(op, dev, blk, 5'($urandom));
  endtask

  // Allocate more tags than slots to hit the full case, then free them.
  task automatic fill_and_drain();
    for (int k = 0; k < SLOTS + 2; k++) send_item(OP_READ, 4'd15, 16'(50000 + k), '0);
    for (int k = 0; k < SLOTS; k++) send_item(OP_RELEASE, '0, '0, 5'(k));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase 0: defaults, no idling.
    set_regs(32'hFFFF_FFFF, 32'h0001_FFFF, 32'd1000);
    send_item(OP_READ, 4'd0, 16'd0, '0);        // stale tag of the most recent slot hits
    send_item(OP_READ, 4'd3, 16'd77, '0);       // miss: least recent free slot (slot 0)
    send_item(OP_READ, 4'd15, 16'hFFFF, '0);    // miss: slot 1, top block
    send_item(OP_READ, 4'd3, 16'd77, '0);       // hit
    send_item(OP_WRITE, '0, '0, 5'd0);
    send_item(OP_WRITE, '0, '0, 5'd31);
    send_item(OP_PIN, '0, '0, 5'd1);
    send_item(OP_PIN, '0, '0, 5'd1);
    send_item(OP_UNPIN, '0, '0, 5'd2);          // underflow on an unused slot
    send_item(OP_RELEASE, '0, '0, 5'd3);        // underflow, no reorder
    send_item(3'd5, '0, '0, 5'd31);             // unused operation codes
    send_item(3'd6, 4'hF, 16'hFFFF, 5'd0);
    send_item(3'd7, '0, '0, 5'd17);
    send_item(OP_PIN, '0, '0, 5'd31);
    send_item(OP_UNPIN, '0, '0, 5'd31);
    send_item(OP_RELEASE, '0, '0, 5'd31);       // count reaches zero: move to most recent
    send_item(OP_READ, 4'd8, 16'h8000, '0);

    // Drive slot 0 to saturation by read hits, overflow a pin, then drain it.
    for (int k = 0; k < CNT_MAX; k++) send_item(OP_READ, 4'd3, 16'd77, '0);
    send_item(OP_PIN, '0, '0, 5'd0);
    for (int k = 0; k <= CNT_MAX; k++) send_item(OP_RELEASE, '0, '0, 5'd0);

    // Phase 1: disk 0 failed, sender idles.
    set_regs(32'd0, 32'd5, 32'd0);
    gap_pct = 63;
    repeat (80) random_item();

    // Phase 2: disk 1 failed and top block bad, receiver stalls.
    set_regs(32'd1, 32'd65535, 32'd65535);
    gap_pct = 0; stall_pct = 63;
    send_item(OP_WRITE, '0, '0, 5'd1);          // no mirror can take it
    send_item(OP_READ, 4'd9, 16'hFFFF, '0);     // no disk can serve it
    fill_and_drain();
    repeat (60) random_item();

    // Phase 3: failure pattern -2 (none), both sides idle; pause once mid-run.
    set_regs(32'd2, 32'd0, 32'd12345);
    gap_pct = 21; stall_pct = 21;
    repeat (40) random_item();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) random_item();

    // Phase 4: no failure, small bad block, full speed.
    set_regs(32'hFFFF_FFFF, 32'd3, 32'd1);
    gap_pct = 0; stall_pct = 0;
    repeat (80) random_item();

    wait_idle();
    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("covered hits, misses, full cache, saturation and all disk failure modes");
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
